[rtl/core/esvi_pkg.sv]
// Shared types and constants for the even-spread subvoxel indexer.
package esvi_pkg;

  localparam int UNIT_W      = 17;  // unit_total register
  localparam int VOXEL_W     = 13;  // voxel_total register
  localparam int UNIT_IDX_W  = 16;
  localparam int VOXEL_IDX_W = 12;
  localparam int OFFSET_W    = 6;
  localparam int DIV_OUT_W   = 7;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  // Register indexes (byte address / 4)
  localparam logic REG_UNIT_TOTAL  = 1'b0;
  localparam logic REG_VOXEL_TOTAL = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic search_init;  // d = 1
    logic search_mul;   // product = d^3 * voxel_total
    logic search_next;  // d = d + 1
    logic finish;       // start the walk, load restart result
    logic step;         // advance one subvoxel, load step result
  } esvi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic search_more;  // product still short of unit_total
  } esvi_status_t;

endpackage

[rtl/core/esvi_ctrl.sv]
// Controller: request/result handshake and division search sequencing.
module esvi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_valid,
  output logic                  step_ready,
  input  logic                  restart,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  esvi_pkg::esvi_status_t status,
  output esvi_pkg::esvi_cmd_t    cmd
);
  import esvi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state, state_next;
  logic       result_valid_next;
  logic       out_free;
  logic       accept;

  assign out_free   = !result_valid || result_ready;
  assign step_ready = (state == ST_IDLE) && out_free;
  assign accept     = step_valid && step_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (restart) begin
            cmd.search_init = 1'b1;
            state_next      = ST_MUL;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.search_mul = 1'b1;
        state_next     = ST_CMP;
      end
      ST_CMP: begin
        if (status.search_more) begin
          cmd.search_next = 1'b1;
          state_next      = ST_MUL;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step || cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

[rtl/core/esvi_dp.sv]
// Datapath: division search, Bresenham walk state, ripple digits, result register.
module esvi_dp #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  esvi_pkg::esvi_cmd_t                 cmd,
  output esvi_pkg::esvi_status_t              status,
  input  logic [esvi_pkg::UNIT_W-1:0]         unit_total,
  input  logic [esvi_pkg::VOXEL_W-1:0]        voxel_total,
  output logic                                selected,
  output logic [esvi_pkg::UNIT_IDX_W-1:0]     unit_index,
  output logic [esvi_pkg::VOXEL_IDX_W-1:0]    voxel_index,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_x,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_y,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_z,
  output logic [esvi_pkg::DIV_OUT_W-1:0]      divisions,
  output logic                                walk_done
);
  import esvi_pkg::*;

  localparam int DW     = $clog2(MAX_DIVISIONS + 1);
  localparam int SQ_W   = 2 * DW;
  localparam int CUBE_W = 3 * DW;
  localparam int S_W    = VOXEL_W + CUBE_W;
  localparam int ERR_W  = S_W + UNIT_W + 3;
  localparam int CMP_W  = S_W + UNIT_W;
  localparam int EXT_W  = DW + DIV_OUT_W;

  // Search registers
  logic [DW-1:0]     cand_d;
  logic [SQ_W-1:0]   cand_sq;
  logic [CUBE_W-1:0] cand_cube;
  logic [S_W-1:0]    product;

  // Walk state
  logic signed [ERR_W-1:0] error_term;
  logic [S_W-1:0]          step_index;
  logic [S_W-1:0]          subvoxel_count;
  logic [DW-1:0]           division_count;
  logic [DW-1:0]           digit_x, digit_y, digit_z;
  logic [VOXEL_W-1:0]      voxel_counter;
  logic [UNIT_W-1:0]       unit_counter;

  logic [S_W-1:0] product_mul;
  assign product_mul = cand_cube * voxel_total;

  assign status.search_more = (voxel_total != '0) && (cand_d < DW'(MAX_DIVISIONS)) &&
                              (CMP_W'(product) < CMP_W'(unit_total));

  // Step arithmetic
  logic                    active, sel;
  logic signed [ERR_W-1:0] two_u, two_s, err_step;
  logic [DW-1:0]           zp1, yp1, xp1;
  logic                    z_wrap, y_wrap, x_wrap;
  logic [S_W-1:0]          step_inc;

  assign active   = step_index < subvoxel_count;
  assign sel      = active && (error_term > 0) && (unit_counter < unit_total);
  assign two_u    = $signed(ERR_W'({unit_total, 1'b0}));
  assign two_s    = $signed(ERR_W'({subvoxel_count, 1'b0}));
  assign err_step = error_term + two_u - (sel ? two_s : '0);
  assign zp1      = digit_z + DW'(1);
  assign yp1      = digit_y + DW'(1);
  assign xp1      = digit_x + DW'(1);
  assign z_wrap   = zp1 >= division_count;
  assign y_wrap   = yp1 >= division_count;
  assign x_wrap   = xp1 >= division_count;
  assign step_inc = step_index + S_W'(1);

  // Digit extension to output widths for any DW
  logic [EXT_W-1:0] ext_x, ext_y, ext_z, ext_div_cur, ext_div_new;
  assign ext_x       = EXT_W'(digit_x);
  assign ext_y       = EXT_W'(digit_y);
  assign ext_z       = EXT_W'(digit_z);
  assign ext_div_cur = EXT_W'(division_count);
  assign ext_div_new = EXT_W'(cand_d);

  // Search sequencing
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      cand_d    <= DW'(1);
      cand_sq   <= SQ_W'(1);
      cand_cube <= CUBE_W'(1);
    end else if (cmd.search_next) begin
      // (d+1)^2 = d^2 + 2d + 1, (d+1)^3 = d^3 + 3d^2 + 3d + 1
      cand_d    <= cand_d + DW'(1);
      cand_sq   <= cand_sq + SQ_W'({cand_d, 1'b0}) + SQ_W'(1);
      cand_cube <= cand_cube + CUBE_W'({cand_sq, 1'b0}) + CUBE_W'(cand_sq) +
                   CUBE_W'({cand_d, 1'b0}) + CUBE_W'(cand_d) + CUBE_W'(1);
    end
    if (cmd.search_mul) begin
      product <= product_mul;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_term     <= '0;
      step_index     <= '0;
      subvoxel_count <= '0;
      division_count <= DW'(1);
      digit_x        <= '0;
      digit_y        <= '0;
      digit_z        <= '0;
      voxel_counter  <= '0;
      unit_counter   <= '0;
    end else if (cmd.finish) begin
      division_count <= cand_d;
      subvoxel_count <= product;
      error_term     <= two_u - $signed(ERR_W'(product));
      step_index     <= '0;
      digit_x        <= '0;
      digit_y        <= '0;
      digit_z        <= '0;
      voxel_counter  <= '0;
      unit_counter   <= '0;
    end else if (cmd.step && active) begin
      error_term <= err_step;
      step_index <= step_inc;
      if (sel) begin
        unit_counter <= unit_counter + UNIT_W'(1);
      end
      if (!z_wrap) begin
        digit_z <= zp1;
      end else begin
        digit_z <= '0;
        if (!y_wrap) begin
          digit_y <= yp1;
        end else begin
          digit_y <= '0;
          if (!x_wrap) begin
            digit_x <= xp1;
          end else begin
            digit_x       <= '0;
            voxel_counter <= voxel_counter + VOXEL_W'(1);
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      selected    <= 1'b0;
      unit_index  <= '0;
      voxel_index <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
      divisions   <= ext_div_new[DIV_OUT_W-1:0];
      walk_done   <= (product == '0);
    end else if (cmd.step) begin
      selected    <= sel;
      unit_index  <= sel ? unit_counter[UNIT_IDX_W-1:0] : '0;
      voxel_index <= sel ? voxel_counter[VOXEL_IDX_W-1:0] : '0;
      offset_x    <= sel ? ext_x[OFFSET_W-1:0] : '0;
      offset_y    <= sel ? ext_y[OFFSET_W-1:0] : '0;
      offset_z    <= sel ? ext_z[OFFSET_W-1:0] : '0;
      divisions   <= ext_div_cur[DIV_OUT_W-1:0];
      walk_done   <= active ? (step_inc >= subvoxel_count) : 1'b1;
    end
  end

endmodule

[rtl/core/even_spread_subvoxel_indexer_unit.sv]
// Top level of the even-spread subvoxel indexer: config registers, controller, datapath.
//
//   channel   direction  handshake                  payload
//   step      in         step_valid / step_ready    restart
//   result    out        result_valid / result_ready selected, unit_index, voxel_index,
//                                                   offset_x/y/z, divisions, walk_done
//   config    in         APB psel/penable/pwrite    unit_total @0x0, voxel_total @0x4
//
// A step request (restart = 0) is one wide add and compare on the error term; its result
// is registered for the next cycle, so steps flow one per cycle while the result side keeps up.
// A restart request walks the division search, a multiply state then a compare state per
// candidate d, for d up to MAX_DIVISIONS, then a finish state that loads the result.
// One request is in flight at a time; step_ready drops while a search runs or while the
// result register holds an untaken result.
// Synchronous reset clears the walk (no subvoxels, divisions = 1) and both registers.
module even_spread_subvoxel_indexer_unit #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                step_valid,
  output logic                                step_ready,
  input  logic                                restart,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                selected,
  output logic [esvi_pkg::UNIT_IDX_W-1:0]     unit_index,
  output logic [esvi_pkg::VOXEL_IDX_W-1:0]    voxel_index,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_x,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_y,
  output logic [esvi_pkg::OFFSET_W-1:0]       offset_z,
  output logic [esvi_pkg::DIV_OUT_W-1:0]      divisions,
  output logic                                walk_done,
  // APB config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esvi_pkg::ADDR_W-1:0]         paddr,
  input  logic [esvi_pkg::DATA_W-1:0]         pwdata,
  output logic [esvi_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import esvi_pkg::*;

  logic [UNIT_W-1:0]  unit_total;
  logic [VOXEL_W-1:0] voxel_total;
  logic               cfg_wr;
  logic               reg_sel;
  esvi_cmd_t          cmd;
  esvi_status_t       status;

  // Register file: word index is paddr[2]; byte offset bits ignored.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_total  <= '0;
      voxel_total <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_UNIT_TOTAL:  unit_total  <= pwdata[UNIT_W-1:0];
        REG_VOXEL_TOTAL: voxel_total <= pwdata[VOXEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_UNIT_TOTAL:  prdata = DATA_W'(unit_total);
      REG_VOXEL_TOTAL: prdata = DATA_W'(voxel_total);
      default:         prdata = '0;
    endcase
  end

  // Sequencer: owns both handshakes and the search loop.
  esvi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Walk state, search arithmetic and the result register.
  esvi_dp #(
    .MAX_DIVISIONS (MAX_DIVISIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .unit_total  (unit_total),
    .voxel_total (voxel_total),
    .selected    (selected),
    .unit_index  (unit_index),
    .voxel_index (voxel_index),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .offset_z    (offset_z),
    .divisions   (divisions),
    .walk_done   (walk_done)
  );

endmodule

[rtl/core/esvi_checker.sv]
// Port-level assertions for the even-spread subvoxel indexer, bound to the top level.
module esvi_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                step_valid,
  input logic                                step_ready,
  input logic                                restart,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic                                selected,
  input logic [esvi_pkg::UNIT_IDX_W-1:0]     unit_index,
  input logic [esvi_pkg::VOXEL_IDX_W-1:0]    voxel_index,
  input logic [esvi_pkg::OFFSET_W-1:0]       offset_x,
  input logic [esvi_pkg::OFFSET_W-1:0]       offset_y,
  input logic [esvi_pkg::OFFSET_W-1:0]       offset_z,
  input logic [esvi_pkg::DIV_OUT_W-1:0]      divisions,
  input logic                                walk_done
);

  // No result survives reset.
  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(selected) &&
      $stable(unit_index) && $stable(voxel_index) && $stable(walk_done))
    else $error("stalled result changed");

  // A plain step request yields its result in the next cycle.
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    step_valid && step_ready && !restart |=> result_valid)
    else $error("step result not presented one cycle after accept");

  // An unselected result carries no position.
  a_unsel_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !selected |-> unit_index == '0 && voxel_index == '0 &&
      offset_x == '0 && offset_y == '0 && offset_z == '0)
    else $error("unselected result carries a position");

  // Divisions are never zero on a result.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> divisions != '0)
    else $error("zero divisions reported");

endmodule

bind even_spread_subvoxel_indexer_unit esvi_checker u_esvi_checker (.*);

[tb/even_spread_subvoxel_indexer_unit_test.sv]
// Self-checking testbench for the even-spread subvoxel indexer: predictor, drivers, checks.
module even_spread_subvoxel_indexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esvi_pkg::*;

  localparam int MAX_DIV = 64;
  localparam int RANDOM_ITEMS = 1600;
  // No request or result for this many cycles means the block is hung.
  // Slowest legal gap: a full division search plus the result-side hold-off (HOLD_OFF_CYCLES).
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;

  // One result item as the block reports it.
  typedef struct packed {
    logic                   selected;
    logic [UNIT_IDX_W-1:0]  unit_index;
    logic [VOXEL_IDX_W-1:0] voxel_index;
    logic [OFFSET_W-1:0]    offset_x;
    logic [OFFSET_W-1:0]    offset_y;
    logic [OFFSET_W-1:0]    offset_z;
    logic [DIV_OUT_W-1:0]   divisions;
    logic                   walk_done;
  } placement_t;

  // Predicts the placement for every accepted request and checks results in order.
  class subvoxel_walk_model;
    logic [UNIT_W-1:0]      unit_total;
    logic [VOXEL_W-1:0]     voxel_total;
    longint                 err_acc;       // Bresenham decision term
    longint                 visited;       // subvoxels stepped over
    longint                 subvoxels;     // voxels * d^3 for the current walk
    int unsigned            div;
    int unsigned            dig_x, dig_y, dig_z;
    logic [VOXEL_IDX_W-1:0] voxel_ctr;
    logic [UNIT_W-1:0]      unit_ctr;
    placement_t             expected_placements[$];
    int                     failures, requests, restarts, placed, max_div;

    function new();
      unit_total = '0;
      voxel_total = '0;
      err_acc = 0;
      visited = 0;
      subvoxels = 0;
      div = 1;
      dig_x = 0;
      dig_y = 0;
      dig_z = 0;
      voxel_ctr = '0;
      unit_ctr = '0;
      failures = 0;
      requests = 0;
      restarts = 0;
      placed = 0;
      max_div = 1;
    endfunction

    // Smallest d with d^3 * voxels >= units, capped at MAX_DIV; 1 when there are no voxels.
    function int unsigned search_divisions(longint units, longint voxels);
      longint d;
      d = 1;
      if (voxels != 0)
        while (d < MAX_DIV && d * d * d * voxels < units) d++;
      return int'(d);
    endfunction

    function void set_register(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_UNIT_TOTAL) unit_total = value[UNIT_W-1:0];
      else voxel_total = value[VOXEL_W-1:0];
    endfunction

    function int outstanding();
      return expected_placements.size();
    endfunction

    function void note_request(logic restart_req);
      placement_t p;
      p = '0;
      requests++;
      if (restart_req) begin
        restarts++;
        div = search_divisions(longint'(unit_total), longint'(voxel_total));
        if (div > max_div) max_div = div;
        subvoxels = longint'(voxel_total) * div * div * div;
        err_acc = 2 * longint'(unit_total) - subvoxels;
        visited = 0;
        dig_x = 0;
        dig_y = 0;
        dig_z = 0;
        voxel_ctr = '0;
        unit_ctr = '0;
      end else if (visited < subvoxels) begin
        // unit_total is read live: never hand out more units than configured
        if (err_acc > 0 && unit_ctr < unit_total) begin
          p.selected = 1'b1;
          p.unit_index = unit_ctr[UNIT_IDX_W-1:0];
          p.voxel_index = voxel_ctr;
          p.offset_x = dig_x[OFFSET_W-1:0];
          p.offset_y = dig_y[OFFSET_W-1:0];
          p.offset_z = dig_z[OFFSET_W-1:0];
          err_acc -= 2 * subvoxels;
          unit_ctr++;
          placed++;
        end
        err_acc += 2 * longint'(unit_total);
        // z fastest, then y, x, voxel
        dig_z++;
        if (dig_z >= div) begin
          dig_z = 0;
          dig_y++;
          if (dig_y >= div) begin
            dig_y = 0;
            dig_x++;
            if (dig_x >= div) begin
              dig_x = 0;
              voxel_ctr++;
            end
          end
        end
        visited++;
      end
      p.divisions = div[DIV_OUT_W-1:0];
      p.walk_done = (visited >= subvoxels);
      expected_placements.push_back(p);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        failures++;
      end
    endfunction

    function void check_placement(placement_t act);
      placement_t exp_p;
      if (expected_placements.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      exp_p = expected_placements.pop_front();
      compare_field("selected", exp_p.selected, act.selected);
      compare_field("unit_index", exp_p.unit_index, act.unit_index);
      compare_field("voxel_index", exp_p.voxel_index, act.voxel_index);
      compare_field("offset_x", exp_p.offset_x, act.offset_x);
      compare_field("offset_y", exp_p.offset_y, act.offset_y);
      compare_field("offset_z", exp_p.offset_z, act.offset_z);
      compare_field("divisions", exp_p.divisions, act.divisions);
      compare_field("walk_done", exp_p.walk_done, act.walk_done);
    endfunction
  endclass

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  // Request channel
  logic step_valid = 1'b0;
  logic step_ready;
  logic restart = 1'b0;

  // Result channel
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic                   selected;
  logic [UNIT_IDX_W-1:0]  unit_index;
  logic [VOXEL_IDX_W-1:0] voxel_index;
  logic [OFFSET_W-1:0]    offset_x;
  logic [OFFSET_W-1:0]    offset_y;
  logic [OFFSET_W-1:0]    offset_z;
  logic [DIV_OUT_W-1:0]   divisions;
  logic                   walk_done;

  // APB config port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  even_spread_subvoxel_indexer_unit DUT (
    .clk(clk),
    .rst(rst),
    .step_valid(step_valid),
    .step_ready(step_ready),
    .restart(restart),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .selected(selected),
    .unit_index(unit_index),
    .voxel_index(voxel_index),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .offset_z(offset_z),
    .divisions(divisions),
    .walk_done(walk_done),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  subvoxel_walk_model model = new();

  // steady and pressure_req are shared between the stimulus and result-side processes.
  bit steady = 1'b0;        // no idling on either side while set
  bit pressure_req = 1'b0;  // asks the receiver for one long hold-off
  int sent_items = 0;
  int config_phases = 0;

  // Monitor: both handshakes are sampled at the rising edge, before any NBA update.
  // Also the watchdog: counts edges with no request, result or register access.
  always @(posedge clk) begin
    bit progress;
    static int idle_cycles = 0;
    progress = 1'b0;
    if (!rst) begin
      if (step_valid && step_ready) begin
        model.note_request(restart);
        progress = 1'b1;
      end
      if (result_valid && result_ready) begin
        model.check_placement('{selected, unit_index, voxel_index, offset_x, offset_y,
                                offset_z, divisions, walk_done});
        progress = 1'b1;
      end
      if (psel && penable && pready) progress = 1'b1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: stalls about 19% of cycles, never during the steady phase, and
  // once holds off for a long stretch so the block backs up into the request side.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  // Offer one request and hold it until taken; then maybe idle a few cycles.
  // valid stays high across back-to-back requests, so it is never lowered and
  // raised in the same time step.
  task automatic send_request(input logic restart_req);
    int gap;
    step_valid <= 1'b1;
    restart <= restart_req;
    @(posedge clk);
    while (!step_ready) @(posedge clk);
    sent_items++;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < 19) gap++;
    if (gap > 0) begin
      step_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // APB write, then read back the same register; ends with the bus returned to idle.
  task automatic program_register(input logic idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model.set_register(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, prdata);
      model.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every outstanding request has produced its result.
  task automatic drain();
    do @(posedge clk); while (model.outstanding() != 0);
  endtask

  // One configuration: program both registers (block idle), restart, then step.
  // restart_pct injects restarts into the middle of the walk.
  task automatic run_phase(input logic [UNIT_W-1:0] units, input logic [VOXEL_W-1:0] voxels,
                           input int steps, input int restart_pct);
    program_register(REG_UNIT_TOTAL, DATA_W'(units));
    program_register(REG_VOXEL_TOTAL, DATA_W'(voxels));
    config_phases++;
    send_request(1'b1);
    repeat (steps) send_request($urandom_range(99) < restart_pct);
    step_valid <= 1'b0;
    drain();
  endtask

  initial begin
    int random_start, kind, steps, pct, phase_no;
    logic [UNIT_W-1:0] units;
    logic [VOXEL_W-1:0] voxels;
    longint walk_len;
    int unsigned d;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // steps before any restart behave as a finished walk
    send_request(1'b0);
    send_request(1'b0);
    step_valid <= 1'b0;
    drain();
    run_phase(17'd0, 13'd0, 1, 0);        // nothing configured
    run_phase(17'd5, 13'd0, 2, 0);        // units but zero voxels: nothing selected
    run_phase(17'd0, 13'd3, 3, 0);        // voxels but no units, walk runs out
    run_phase(17'd8, 13'd1, 8, 0);        // units equal subvoxels: every step selected
    run_phase(17'd65536, 13'd4096, 2, 0); // large settings: 65536 units, 4096 voxels

    // --- random: mostly complete walks on small areas, a few large ones ---
    random_start = sent_items;
    phase_no = 0;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      phase_no++;
      steady = (phase_no == 4);
      kind = $urandom_range(9);
      if (kind == 0) begin
        case ($urandom_range(3))
          0: begin units = 17'd65536; voxels = 13'd1; end
          1: begin units = 17'd65536; voxels = 13'd4096; end
          2: begin
            units = UNIT_W'($urandom_range(0, 65536));
            voxels = VOXEL_W'($urandom_range(0, 4096));
          end
          default: begin units = 17'd0; voxels = 13'd4096; end
        endcase
        steps = $urandom_range(40, 160);
      end else begin
        voxels = VOXEL_W'($urandom_range(0, 8));
        units = (kind < 4) ? UNIT_W'($urandom_range(0, voxels * 125 + 3))
                           : UNIT_W'($urandom_range(0, voxels * 27 + 3));
        d = model.search_divisions(longint'(units), longint'(voxels));
        walk_len = longint'(voxels) * d * d * d;
        steps = (walk_len <= 300) ? int'(walk_len) + $urandom_range(0, 3)
                                  : $urandom_range(100, 300);
      end
      // broken sequences: restarts dropped into the walk
      pct = (kind >= 8) ? 8 : 0;
      // the no-idle phase runs long enough to be a real stretch
      if (steady && steps < 200) steps = 200;
      if (phase_no == 2) begin
        pressure_req = 1'b1;
        if (steps < 20) steps = 20;
      end
      run_phase(units, voxels, steps, pct);
    end
    steady = 1'b0;

    // let any stray result surface: one full division search and some margin
    repeat (2 * MAX_DIV + 10) @(posedge clk);

    $display("Checked %0d requests (%0d restarts) across %0d register settings.",
             model.requests, model.restarts, config_phases);
    $display("%0d subvoxels placed; largest division count %0d.", model.placed,
             model.max_div);
    if (model.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[even_spread_subvoxel_indexer_unit.f]
rtl/core/esvi_pkg.sv
rtl/core/esvi_ctrl.sv
rtl/core/esvi_dp.sv
rtl/core/even_spread_subvoxel_indexer_unit.sv
rtl/core/esvi_checker.sv
tb/even_spread_subvoxel_indexer_unit_test.sv
